// ===== sv/psfc_pkg.sv =====
// Shared widths, codes and defaults for the per-symbol Fenwick counter.
package psfc_pkg;
   localparam int MAX_POSITIONS_DEF = 1024;
   localparam int SYMBOL_COUNT_DEF  = 26;

   localparam int OP_W        = 1;
   localparam int POS_W       = 11;
   localparam int SYM_W       = 5;
   localparam int DELTA_W     = 12;
   localparam int COUNT_W     = 16;
   localparam int LEN_W       = 11;
   localparam int IDX_W       = POS_W + 1;
   localparam int REQ_FIELD_W = OP_W + POS_W + SYM_W + DELTA_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((COUNT_W + 7) / 8) * 8;

   localparam logic [LEN_W-1:0] USED_LENGTH_RESET = LEN_W'(1024);

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;
endpackage

// ===== sv/psfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/per_symbol_fenwick_counter_unit.sv =====
// Per-symbol Fenwick tree counter: one binary indexed tree of counts per symbol.
//
// req channel: one beat per item. tdata carries operation (add or prefix query),
// position, symbol and a signed delta. rsp channel: one beat per item with the
// 16-bit count (prefix sum for a query, zero for an add). csr_wen/csr_wdata
// write used_length, the number of positions in use; write only while idle.
//
// Each item walks the symbol's tree through one shared RAM port pair, one node
// per cycle: a node is read in one cycle and added into (add) or accumulated
// (query) the next, overlapped with the read of the following node. An item
// touches at most log2(MAX_POSITIONS)+1 nodes (11 at defaults) and raises
// rsp_tvalid once its walk is done. Only one item is in flight; req_tready
// stays low until its rsp beat is taken.
//
// After reset the node store, SYMBOL_COUNT * 2**ceil(log2(MAX_POSITIONS)) nodes
// (26624 at defaults), is swept to zero one node per cycle; req_tready stays
// low during the sweep. used_length resets to 1024.
// When the receiver stalls, the rsp beat holds and no new req beat is taken.
module per_symbol_fenwick_counter_unit
   import psfc_pkg::*;
#(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
   parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // operation[0], position[11:1], symbol[16:12], delta[28:17], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // count[15:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [LEN_W-1:0]       csr_wdata
);
   localparam int NODE_W  = $clog2(MAX_POSITIONS);
   localparam int SIDX_W  = $clog2(SYMBOL_COUNT);
   localparam int ADDR_W  = SIDX_W + NODE_W;
   localparam int DEPTH   = SYMBOL_COUNT * (2 ** NODE_W);
   localparam int LEN_CAP = (MAX_POSITIONS > 2047) ? 2047 : MAX_POSITIONS;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [LEN_W-1:0]   used_length_ff;
   logic               op_ff, op_in;
   logic [SIDX_W-1:0]  sym_ff, sym_in;
   logic [COUNT_W-1:0] delta_ff, delta_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;

   logic               req_op;
   logic [POS_W-1:0]   req_pos;
   logic [SYM_W-1:0]   req_sym;
   logic [DELTA_W-1:0] req_delta;
   logic [IDX_W-1:0]   eff_len;
   logic [IDX_W-1:0]   pos_ext;
   logic [IDX_W-1:0]   low_bit;
   logic               go;
   logic               req_acc;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [COUNT_W-1:0] wr_data, rd_data;

   assign req_op    = req_tdata[0];
   assign req_pos   = req_tdata[POS_W:1];
   assign req_sym   = req_tdata[POS_W+SYM_W:POS_W+1];
   assign req_delta = req_tdata[REQ_FIELD_W-1:POS_W+SYM_W+1];

   assign eff_len = ({1'b0, used_length_ff} > IDX_W'(LEN_CAP)) ? IDX_W'(LEN_CAP)
                                                                : {1'b0, used_length_ff};
   assign pos_ext = {1'b0, req_pos};
   assign low_bit = idx_ff & (~idx_ff + IDX_W'(1));
   assign go      = (idx_ff != '0) && (idx_ff <= eff_len);
   assign req_acc = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = RSP_TDATA_W'(acc_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      op_in        = op_ff;
      sym_in       = sym_ff;
      delta_in     = delta_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data + delta_ff;
      rd_en        = 1'b0;
      rd_addr      = {sym_ff, NODE_W'(idx_ff - IDX_W'(1))};
      unique case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               op_in    = req_op;
               sym_in   = req_sym[SIDX_W-1:0];
               delta_in = {{(COUNT_W-DELTA_W){req_delta[DELTA_W-1]}}, req_delta};
               acc_in   = '0;
               if ({3'b000, req_sym} >= 8'(SYMBOL_COUNT)) begin
                  idx_in = '0;
               end else if (req_op == OP_QUERY) begin
                  idx_in = (pos_ext > eff_len) ? eff_len : pos_ext;
               end else begin
                  idx_in = pos_ext;
               end
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (go) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = rd_addr;
               idx_in       = (op_ff == OP_QUERY) ? idx_ff - low_bit : idx_ff + low_bit;
            end else begin
               state_in = S_RESP;
            end
            if (pend_ff) begin
               if (op_ff == OP_QUERY) begin
                  acc_in = acc_ff + rd_data;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         used_length_ff <= USED_LENGTH_RESET;
         pend_ff        <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         if (csr_wen) begin
            used_length_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sym_ff       <= sym_in;
      delta_ff     <= delta_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      pend_addr_ff <= pend_addr_in;
   end

   psfc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same node");

   a_update_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (op_ff == OP_UPDATE)) |-> (rsp_tdata == '0))
      else $error("nonzero count on add");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !rsp_tvalid)
      else $error("response in the cycle after accept");

   a_query_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK) && (op_ff == OP_QUERY)) |-> (idx_ff <= eff_len))
      else $error("query walk above effective length");
endmodule
